// ===== src/rhh_pkg.sv =====
// ----------------------------------------------------------------------------
// rhh_pkg
// types and constants shared by the robin hood hash table
// ----------------------------------------------------------------------------
package rhh_pkg;

	localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
	localparam logic [31:0] FNV_PRIME = 32'h01000193;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EXISTS    = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_USED  = 2'd1,
		MARK_TOMB  = 2'd2,
		MARK_SPARE = 2'd3
	} mark_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_HASH,
		S_READ,
		S_PROBE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} hash_ctl_t;

endpackage

// ===== src/rhh_hash.sv =====
// ----------------------------------------------------------------------------
// rhh_hash
// byte-serial fnv-1a hash and key normalisation, one byte a cycle
// ----------------------------------------------------------------------------
module rhh_hash #(
	parameter int KEY_BYTES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [63:0]      key,
	output rhh_pkg::hash_ctl_t ctl,
	output logic [31:0]      hash,
	output logic [63:0]      kept
);
	import rhh_pkg::*;

	localparam int CW = 4;

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [63:0]   raw_q;
	logic [31:0]   h_q;
	logic [63:0]   kept_q;
	logic [7:0]    b;
	logic [2:0]    bi;

	assign bi = cnt_q[2:0];
	assign b  = raw_q[8*bi +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (b == 8'd0 || cnt_q == CW'(KEY_BYTES - 1)) busy_q <= 1'b0;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			raw_q  <= key;
			h_q    <= FNV_BASIS;
			kept_q <= '0;
		end else if (busy_q && b != 8'd0) begin
			h_q <= (h_q ^ {24'd0, b}) * FNV_PRIME;
			kept_q[8*bi +: 8] <= b;
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign hash      = h_q;
	assign kept      = kept_q;
endmodule

// ===== src/robin_hood_hash_table.sv =====
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// open-addressing robin hood hash table keyed by short strings
// ----------------------------------------------------------------------------
// One item at a time: the key is hashed one byte a cycle, then the slot memory
// is walked one slot at a time (read, then compare/swap) from the home slot.
// A refused insert or an unused action probes no slot. Each slot word holds
// its mark, key, hash and value in one memory with a registered read port.
// After reset a clearing pass empties every slot, and in_stall stays high
// until it ends.
module robin_hood_hash_table #(
	parameter int SLOTS     = 256,
	parameter int KEY_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [63:0] key,
	input  logic [63:0] value_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] value_out,
	output logic [8:0]  entry_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);
	import rhh_pkg::*;

	localparam int AW = $clog2(SLOTS);
	localparam int CW = AW + 1;
	localparam int EW = 162;

	state_t state_q, state_d;
	logic [EW-1:0] mem [SLOTS];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] clr_q;

	logic [8:0]    limit_q;
	logic [CW-1:0] occ_q, tomb_q;
	logic [1:0]    act_q;
	logic [63:0]   ck_q, cv_q;
	logic [31:0]   ch_q;
	logic [AW-1:0] idx_q;
	logic [CW:0]   dist_q;
	logic          newc_q;
	logic [1:0]    st_q;
	logic [63:0]   vo_q;
	logic          ov_q;

	hash_ctl_t     hctl;
	logic [31:0]   hh;
	logic [63:0]   hk;
	logic          hstart;

	rhh_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(hstart), .key(key),
		.ctl(hctl), .hash(hh), .kept(hk)
	);

	assign hstart    = (state_q == S_IDLE) && in_valid;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign status    = st_q;
	assign value_out = vo_q;
	assign entry_count = 9'(occ_q);

	logic [63:0]   rk, rv;
	logic [31:0]   rh;
	logic [AW-1:0] rdist;
	mark_t         m;
	logic          match;
	logic          full;
	logic          put, swap, take;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	assign m     = mark_t'(rd_q[161:160]);
	assign rk    = rd_q[159:96];
	assign rh    = rd_q[95:64];
	assign rv    = rd_q[63:0];
	assign rdist = idx_q - rh[AW-1:0];
	assign match = (rh == ch_q) && (rk == ck_q);
	assign full  = (occ_q >= CW'(SLOTS)) ||
		({1'b0, occ_q} + {1'b0, tomb_q} >= (CW+1)'(limit_q));

	assign put  = (act_q == ACT_INSERT) && (m != MARK_USED);
	assign swap = (act_q == ACT_INSERT) && (m == MARK_USED) && !(newc_q && match) &&
		(dist_q > (CW+1)'(rdist));
	assign take = (act_q == ACT_REMOVE) && (m == MARK_USED) && match;

	assign wr_en   = (state_q == S_CLEAR) || ((state_q == S_PROBE) && (put || swap || take));
	assign wr_addr = (state_q == S_CLEAR) ? clr_q : idx_q;
	assign wr_data = (state_q == S_CLEAR) ? '0 :
		take ? {MARK_TOMB, rk, rh, rv} : {MARK_USED, ck_q, ch_q, cv_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_HASH;
			S_CLEAR: if (clr_q == AW'(SLOTS - 1)) state_d = S_IDLE;
			S_HASH:  if (!hctl.busy) state_d = S_READ;
			S_READ:  state_d = S_PROBE;
			S_PROBE: state_d = S_READ;
			S_DONE:  if (!out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_HASH && !hctl.busy &&
			(act_q == ACT_NONE || (act_q == ACT_INSERT && full)))
			state_d = S_DONE;
		if (state_q == S_PROBE) begin
			if (act_q == ACT_INSERT) begin
				if (m != MARK_USED || (newc_q && match)) state_d = S_DONE;
			end else begin
				if (m == MARK_EMPTY) state_d = S_DONE;
				else if (m == MARK_USED && (match || (CW+1)'(rdist) < dist_q))
					state_d = S_DONE;
				else if (dist_q + 1'b1 > (CW+1)'(SLOTS)) state_d = S_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q];
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			limit_q <= 9'(SLOTS * 7 / 10);
			occ_q   <= '0;
			tomb_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_valid && cfg_ready) limit_q <= cfg_data;
			if (ov_q && !out_stall) ov_q <= 1'b0;
			if (state_q == S_PROBE && state_d == S_DONE) ov_q <= 1'b1;
			if (state_q == S_HASH && state_d == S_DONE) ov_q <= 1'b1;
			if (state_q == S_PROBE && put) begin
				if (m == MARK_TOMB && tomb_q != '0) tomb_q <= tomb_q - 1'b1;
				occ_q <= occ_q + 1'b1;
			end
			if (state_q == S_PROBE && take) begin
				if (occ_q != '0) occ_q <= occ_q - 1'b1;
				tomb_q <= tomb_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q <= action;
				cv_q  <= value_in;
			end
			S_HASH: begin
				ck_q   <= hk;
				ch_q   <= hh;
				idx_q  <= hh[AW-1:0];
				dist_q <= '0;
				newc_q <= 1'b1;
				vo_q   <= '0;
				st_q   <= (act_q == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
			end
			S_PROBE: begin
				if (act_q == ACT_INSERT) begin
					if (m != MARK_USED) st_q <= ST_OK;
					else if (newc_q && match) st_q <= ST_EXISTS;
					else if (swap) begin
						ck_q <= rk; ch_q <= rh; cv_q <= rv;
						dist_q <= (CW+1)'(rdist) + 1'b1;
						newc_q <= 1'b0;
						idx_q  <= idx_q + 1'b1;
					end else begin
						dist_q <= dist_q + 1'b1;
						idx_q  <= idx_q + 1'b1;
					end
				end else begin
					if (m == MARK_USED && match) begin
						st_q <= ST_OK;
						if (act_q == ACT_LOOKUP) vo_q <= rv;
					end
					dist_q <= dist_q + 1'b1;
					idx_q  <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== tb/tb_robin_hood_hash_table.sv =====
// ----------------------------------------------------------------------------
// tb_robin_hood_hash_table
// self-checking test of the robin hood hash table: a local table model
// predicts status, value and entry count for every item; results are compared
// in order while both sides idle and stall at random
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_robin_hood_hash_table;
	import rhh_pkg::*;

	localparam int NSLOT = 256;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [63:0] key;
	logic [63:0] value_in;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [63:0] value_out;
	logic [8:0]  entry_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [8:0]  cfg_data;

	robin_hood_hash_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .key(key), .value_in(value_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .value_out(value_out), .entry_count(entry_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	typedef struct packed {
		status_t     st;
		logic [63:0] val;
		logic [8:0]  cnt;
	} answer_t;

	// local copy of the table
	mark_t       tbl_mark [NSLOT];
	logic [63:0] tbl_key  [NSLOT];
	logic [31:0] tbl_hash [NSLOT];
	logic [63:0] tbl_val  [NSLOT];
	int unsigned n_used;
	int unsigned n_tomb;
	int unsigned fill_lim;

	answer_t     answer_q[$];
	int unsigned errors;
	int unsigned n_sent;
	int unsigned n_checked;
	int unsigned n_full;
	int unsigned n_exists;
	int          send_idle_pct;
	int          recv_idle_pct;
	logic [63:0] key_pool[$];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] trim_key(input logic [63:0] raw, output logic [31:0] h);
		logic [63:0] kept;
		logic        stop;
		kept = '0;
		h = FNV_BASIS;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!stop) begin
				if (raw[8*i +: 8] == 8'd0) begin
					stop = 1'b1;
				end else begin
					h = (h ^ {24'd0, raw[8*i +: 8]}) * FNV_PRIME;
					kept[8*i +: 8] = raw[8*i +: 8];
				end
			end
		end
		return kept;
	endfunction

	function automatic int probe_gap(input logic [31:0] h, input int idx);
		return (idx - int'(h[7:0])) & (NSLOT - 1);
	endfunction

	function automatic int locate(input logic [63:0] k, input logic [31:0] h);
		int idx;
		int steps;
		idx = h[7:0];
		steps = 0;
		while (tbl_mark[idx] != MARK_EMPTY) begin
			if (tbl_mark[idx] == MARK_USED) begin
				if (tbl_hash[idx] == h && tbl_key[idx] == k)
					return idx;
				if (probe_gap(tbl_hash[idx], idx) < steps)
					return NSLOT;
			end
			idx = (idx + 1) & (NSLOT - 1);
			steps++;
			if (steps > NSLOT)
				return NSLOT;
		end
		return NSLOT;
	endfunction

	function automatic status_t table_insert(input logic [63:0] k, input logic [31:0] h,
			input logic [63:0] v);
		int          idx;
		int          steps;
		int          res;
		bit          fresh;
		logic [63:0] tk;
		logic [31:0] th;
		logic [63:0] tv;
		if (n_used >= NSLOT || n_used + n_tomb >= fill_lim)
			return ST_FULL;
		idx = h[7:0];
		steps = 0;
		fresh = 1'b1;
		while (tbl_mark[idx] == MARK_USED) begin
			if (fresh && tbl_hash[idx] == h && tbl_key[idx] == k)
				return ST_EXISTS;
			res = probe_gap(tbl_hash[idx], idx);
			if (steps > res) begin
				tk = tbl_key[idx];
				th = tbl_hash[idx];
				tv = tbl_val[idx];
				tbl_key[idx] = k;
				tbl_hash[idx] = h;
				tbl_val[idx] = v;
				k = tk;
				h = th;
				v = tv;
				steps = res;
				fresh = 1'b0;
			end
			idx = (idx + 1) & (NSLOT - 1);
			steps++;
		end
		if (tbl_mark[idx] == MARK_TOMB && n_tomb > 0)
			n_tomb--;
		tbl_mark[idx] = MARK_USED;
		tbl_key[idx] = k;
		tbl_hash[idx] = h;
		tbl_val[idx] = v;
		n_used++;
		return ST_OK;
	endfunction

	function automatic answer_t table_apply(input action_t act, input logic [63:0] raw,
			input logic [63:0] v);
		answer_t     a;
		logic [31:0] h;
		logic [63:0] k;
		int          idx;
		k = trim_key(raw, h);
		a.st = ST_NOT_FOUND;
		a.val = '0;
		case (act)
			ACT_INSERT: a.st = table_insert(k, h, v);
			ACT_LOOKUP: begin
				idx = locate(k, h);
				if (idx < NSLOT) begin
					a.st = ST_OK;
					a.val = tbl_val[idx];
				end
			end
			ACT_REMOVE: begin
				idx = locate(k, h);
				if (idx < NSLOT) begin
					tbl_mark[idx] = MARK_TOMB;
					if (n_used > 0)
						n_used--;
					n_tomb++;
					a.st = ST_OK;
				end
			end
			default: ;
		endcase
		a.cnt = n_used[8:0];
		return a;
	endfunction

	task automatic send_item(input action_t act, input logic [63:0] k, input logic [63:0] v);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		in_valid <= 1'b1;
		action <= act;
		key <= k;
		value_in <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		answer_q.push_back(table_apply(act, k, v));
		n_sent++;
		@(negedge clk);
		in_valid <= 1'b0;
		action <= action_t'($urandom_range(3));
		key <= {$urandom, $urandom};
		value_in <= {$urandom, $urandom};
		@(negedge clk);
	endtask

	// checker of each result item
	always @(posedge clk) begin
		answer_t want;
		if (out_valid && !out_stall) begin
			if (answer_q.size() == 0) begin
				$display("%0t: unexpected item status=%0d value=%h count=%0d",
					$time, status, value_out, entry_count);
				errors++;
			end else begin
				want = answer_q.pop_front();
				n_checked++;
				if (status != want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					errors++;
				end
				if (value_out != want.val) begin
					$display("%0t: value expected %h actual %h", $time, want.val, value_out);
					errors++;
				end
				if (entry_count != want.cnt) begin
					$display("%0t: count expected %0d actual %0d", $time, want.cnt, entry_count);
					errors++;
				end
				if (want.st == ST_FULL)
					n_full++;
				if (want.st == ST_EXISTS)
					n_exists++;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic drain;
		while (answer_q.size() != 0)
			@(negedge clk);
		repeat (20)
			@(negedge clk);
	endtask

	task automatic write_limit(input int unsigned lim);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= lim[8:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		fill_lim = lim;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand_key(input int len);
		logic [63:0] k;
		k = '0;
		for (int i = 0; i < len; i++)
			k[8*i +: 8] = 8'($urandom_range(255, 1));
		return k;
	endfunction

	function automatic logic [63:0] pick_key();
		logic [63:0] k;
		logic        stop;
		if (key_pool.size() != 0 && $urandom_range(99) < 70) begin
			k = key_pool[$urandom_range(key_pool.size() - 1)];
			// junk after the terminator names the same key
			if ($urandom_range(3) == 0) begin
				stop = 1'b0;
				for (int i = 0; i < 8; i++) begin
					if (stop)
						k[8*i +: 8] = 8'($urandom);
					else if (k[8*i +: 8] == 8'd0)
						stop = 1'b1;
				end
			end
			return k;
		end
		k = rand_key($urandom_range(8));
		key_pool.push_back(k);
		if (key_pool.size() > 300)
			void'(key_pool.pop_front());
		return k;
	endfunction

	task automatic test_directed;
		send_item(ACT_LOOKUP, 64'd0, 64'd0);
		send_item(ACT_INSERT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(ACT_LOOKUP, 64'd0, 64'd0);
		send_item(ACT_INSERT, 64'h0000_0000_0000_0041, 64'h0123_4567_89AB_CDEF);
		send_item(ACT_INSERT, 64'h0000_0000_0000_0041, 64'd5);
		send_item(ACT_LOOKUP, 64'hFFFF_FF00_0000_0041, 64'd0);
		send_item(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
		send_item(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(ACT_INSERT, 64'h0101_0101_0101_0101, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(ACT_INSERT, 64'h8080_8080_8080_8080, 64'h5555_5555_5555_5555);
		send_item(ACT_NONE, 64'h0000_0000_0000_0041, 64'd1);
		send_item(ACT_REMOVE, 64'h0000_0000_0000_0041, 64'd0);
		send_item(ACT_REMOVE, 64'h0000_0000_0000_0041, 64'd0);
		send_item(ACT_LOOKUP, 64'h0000_0000_0000_0041, 64'd0);
		send_item(ACT_INSERT, 64'h0000_0000_0000_0041, 64'd7);
		send_item(ACT_REMOVE, 64'h00FF_0000_0000_0000, 64'd0);
		send_item(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
	endtask

	// small limit: full answer, also for a key that is present
	task automatic test_fill_limit;
		write_limit(1);
		send_item(ACT_INSERT, 64'h0000_0000_0000_0042, 64'd1);
		send_item(ACT_INSERT, 64'd0, 64'd1);
		send_item(ACT_LOOKUP, 64'd0, 64'd0);
		write_limit(8);
		for (int i = 0; i < 12; i++)
			send_item(ACT_INSERT, rand_key($urandom_range(8, 1)), {$urandom, $urandom});
	endtask

	task automatic random_phase(input int n, input int ins_pct);
		action_t act;
		int      r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < ins_pct)
				act = ACT_INSERT;
			else if (r < ins_pct + (100 - ins_pct) / 2)
				act = ACT_LOOKUP;
			else if (r < 98)
				act = ACT_REMOVE;
			else
				act = ACT_NONE;
			send_item(act, pick_key(), {$urandom, $urandom});
		end
	endtask

	// drive the whole table full, whatever the limit
	task automatic test_whole_table;
		write_limit(511);
		for (int i = 0; i < 290; i++)
			send_item(ACT_INSERT, rand_key($urandom_range(8, 1)), {$urandom, $urandom});
		random_phase(60, 10);
		send_item(ACT_INSERT, 64'h0000_0000_0000_0043, 64'd9);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_INSERT;
		key = '0;
		value_in = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_full = 0;
		n_exists = 0;
		n_used = 0;
		n_tomb = 0;
		fill_lim = 179;
		for (int i = 0; i < NSLOT; i++)
			tbl_mark[i] = MARK_EMPTY;
		send_idle_pct = 25;
		recv_idle_pct = 45;
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		random_phase(300, 50);
		send_idle_pct = 45;
		recv_idle_pct = 25;
		test_fill_limit();
		write_limit(256);
		random_phase(350, 45);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_whole_table();
		write_limit(179);
		random_phase(200, 30);
		drain();
		$display("items sent %0d, results checked %0d, full answers %0d, duplicates %0d",
			n_sent, n_checked, n_full, n_exists);
		$display("covered fill limits 1, 8, 179, 256, 511 and a completely full table");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#100ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
src/rhh_pkg.sv
src/rhh_hash.sv
src/robin_hood_hash_table.sv
tb/tb_robin_hood_hash_table.sv
